>>> src/assert_macros.svh
// Assertion macros used by frustum_aabb_cull_test.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> src/facull_pkg.sv
// Types, constants and plane extraction for the frustum box cull test.
// Self-contained; used by frustum_aabb_cull_test.
`default_nettype none

package facull_pkg;

	localparam int COORD_W = 16;            // Q11.4 box coordinate
	localparam int ENTRY_W = 16;            // Q3.12 matrix entry
	localparam int ROW_W   = 4 * ENTRY_W;   // one packed matrix row
	localparam int COMP_W  = ENTRY_W + 1;   // exact sum of two entries
	localparam int PROD_W  = COMP_W + COORD_W;
	localparam int DIST_W  = PROD_W + 2;    // three products plus scaled offset
	localparam int NUM_PLANES = 6;
	localparam int NUM_AXES   = 3;
	localparam int D_SHIFT    = 4;          // Q.12 offset to Q.16

	typedef enum logic [1:0] {
		REG_ROW_ONE   = 2'd0,
		REG_ROW_TWO   = 2'd1,
		REG_ROW_THREE = 2'd2,
		REG_ROW_FOUR  = 2'd3
	} cfg_reg_t;

	localparam logic [ROW_W-1:0] ROW_ONE_RST   = 64'h0000_0000_0000_1000;
	localparam logic [ROW_W-1:0] ROW_TWO_RST   = 64'h0000_0000_1000_0000;
	localparam logic [ROW_W-1:0] ROW_THREE_RST = 64'h0000_1000_0000_0000;
	localparam logic [ROW_W-1:0] ROW_FOUR_RST  = 64'h1000_0000_0000_0000;

	typedef logic [3:0][ROW_W-1:0] matrix_t;
	typedef logic signed [COMP_W-1:0] comp_t;

	// Plane: normal components (rows 1-3) and offset (row 4).
	typedef struct packed {
		comp_t [2:0] n;
		comp_t       d;
	} plane_t;

	// Plane built as (use column 4) + or - (other column).
	typedef struct packed {
		logic       use_c4;
		logic [1:0] col;
		logic       sub;
	} plane_def_t;

	localparam plane_def_t PLANE_DEF [NUM_PLANES] = '{
		'{use_c4: 1'b1, col: 2'd0, sub: 1'b0},   // left
		'{use_c4: 1'b1, col: 2'd0, sub: 1'b1},   // right
		'{use_c4: 1'b1, col: 2'd1, sub: 1'b1},   // top
		'{use_c4: 1'b1, col: 2'd1, sub: 1'b0},   // bottom
		'{use_c4: 1'b0, col: 2'd2, sub: 1'b0},   // near
		'{use_c4: 1'b1, col: 2'd2, sub: 1'b1}    // far
	};

	// Build one clip plane from the matrix columns; the sums are exact.
	function automatic plane_t plane_of(input matrix_t m, input plane_def_t pd);
		plane_t p;
		comp_t  e4;
		comp_t  eo;
		comp_t  c;
		for (int r = 0; r < 4; r++) begin
			e4 = COMP_W'($signed(m[r][3*ENTRY_W +: ENTRY_W]));
			eo = COMP_W'($signed(m[r][pd.col*ENTRY_W +: ENTRY_W]));
			c = (pd.use_c4 ? e4 : '0) + (pd.sub ? -eo : eo);
			if (r == 3) begin
				p.d = c;
			end else begin
				p.n[r] = c;
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

>>> src/frustum_aabb_cull_test.sv
// Frustum versus axis-aligned box cull test, three-stage pipeline.
// Depends on facull_pkg and assert_macros.svh.
//
// Usage:
//  - Config: write the four matrix rows through cfg_we/cfg_index/cfg_data
//    while no request is in flight. Each row packs four signed Q3.12 entries,
//    column 1 in the low bits. Reset loads the identity matrix.
//  - Input: one box request (signed Q11.4 min and max corners) is taken on a
//    rising edge with in_valid high and in_stall low.
//  - Output: box_visible is offered with out_valid; it is taken on an edge with
//    out_stall low. It is 0 when some clip plane puts the whole box outside.
//  - Path: a request passes the input register, the product register and the
//    result register before out_valid rises; out_stall can hold it on the way.
//  - Throughput: one box per cycle unless out_stall holds a full pipe; the
//    eighteen plane-by-corner products are computed side by side in the second stage.
//  - Stall: out_stall holds the result register; bubbles ahead of it still
//    collapse, and in_stall rises only when all three stages are full.
//  - Reset: arst_n clears every valid bit and restores the identity matrix.
`default_nettype none
`include "assert_macros.svh"

module frustum_aabb_cull_test (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Config port
	input  wire logic                                   cfg_we,
	input  wire logic [1:0]                             cfg_index,
	input  wire logic [facull_pkg::ROW_W-1:0]           cfg_data,
	// Box requests
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [facull_pkg::COORD_W-1:0]  box_min_x,
	input  wire logic signed [facull_pkg::COORD_W-1:0]  box_min_y,
	input  wire logic signed [facull_pkg::COORD_W-1:0]  box_min_z,
	input  wire logic signed [facull_pkg::COORD_W-1:0]  box_max_x,
	input  wire logic signed [facull_pkg::COORD_W-1:0]  box_max_y,
	input  wire logic signed [facull_pkg::COORD_W-1:0]  box_max_z,
	// Results
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic                                        box_visible
);

	localparam int NP = facull_pkg::NUM_PLANES;
	localparam int NA = facull_pkg::NUM_AXES;

	facull_pkg::matrix_t rows_q;
	facull_pkg::plane_t  plane_q [NP];

	logic v_s1;
	logic v_s2;
	logic en_s1;
	logic en_s2;
	logic en_s3;

	logic signed [facull_pkg::COORD_W-1:0] min_s1 [NA];
	logic signed [facull_pkg::COORD_W-1:0] max_s1 [NA];

	logic signed [facull_pkg::PROD_W-1:0] prod_d [NP][NA];
	logic signed [facull_pkg::PROD_W-1:0] prod_s2 [NP][NA];

	logic visible_d;

	// Hold the matrix rows; writes beyond the list do not exist on a 2-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[facull_pkg::REG_ROW_ONE]   <= facull_pkg::ROW_ONE_RST;
			rows_q[facull_pkg::REG_ROW_TWO]   <= facull_pkg::ROW_TWO_RST;
			rows_q[facull_pkg::REG_ROW_THREE] <= facull_pkg::ROW_THREE_RST;
			rows_q[facull_pkg::REG_ROW_FOUR]  <= facull_pkg::ROW_FOUR_RST;
		end else if (cfg_we) begin
			rows_q[cfg_index] <= cfg_data;
		end
	end

	// Extract the six clip planes from the matrix columns
	always_ff @(posedge clk) begin
		for (int p = 0; p < NP; p++) begin
			plane_q[p] <= facull_pkg::plane_of(rows_q, facull_pkg::PLANE_DEF[p]);
		end
	end

	// Advance each stage when it is empty or the next one moves
	assign en_s3    = !out_valid || !out_stall;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				out_valid <= v_s2;
			end
		end
	end

	// Stage 1: capture the box corners
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			min_s1[0] <= box_min_x;
			min_s1[1] <= box_min_y;
			min_s1[2] <= box_min_z;
			max_s1[0] <= box_max_x;
			max_s1[1] <= box_max_y;
			max_s1[2] <= box_max_z;
		end
	end

	// Pick the far corner per axis and multiply by the plane normal
	always_comb begin
		logic signed [facull_pkg::COORD_W-1:0] sel;
		facull_pkg::comp_t                     c;
		for (int p = 0; p < NP; p++) begin
			for (int a = 0; a < NA; a++) begin
				c = plane_q[p].n[a];
				sel = (!c[facull_pkg::COMP_W-1] && (c != '0)) ? max_s1[a] : min_s1[a];
				prod_d[p][a] = facull_pkg::PROD_W'(c) * facull_pkg::PROD_W'(sel);
			end
		end
	end

	// Stage 2: hold the products
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			prod_s2 <= prod_d;
		end
	end

	// Sum the distance per plane; any strictly negative one culls the box
	always_comb begin
		logic signed [facull_pkg::DIST_W-1:0] plane_dist;
		visible_d = 1'b1;
		for (int p = 0; p < NP; p++) begin
			plane_dist = facull_pkg::DIST_W'(plane_q[p].d) <<< facull_pkg::D_SHIFT;
			for (int a = 0; a < NA; a++) begin
				plane_dist = plane_dist + facull_pkg::DIST_W'(prod_s2[p][a]);
			end
			if (plane_dist[facull_pkg::DIST_W-1]) begin
				visible_d = 1'b0;
			end
		end
	end

	// Stage 3: result register
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			box_visible <= visible_d;
		end
	end

	`ASSERT_CLK(a_accept_fills_s1, (in_valid && !in_stall) |=> v_s1, "accepted request lost")
	`ASSERT_CLK(a_stall_only_full, in_stall |-> (v_s1 && v_s2 && out_valid && out_stall), "input stalled with room in the pipe")
	`ASSERT_CLK(a_s2_to_out, (v_s2 && !out_valid) |=> out_valid, "stage 2 did not move into empty output")

endmodule

`default_nettype wire
